/* rtl/core/hcbm_pkg.sv */
// Shared types and constants for the hysteretic charge balance meter.
// No dependencies; imported by every module of the block.
package hcbm_pkg;

    localparam int CODE_W  = 16;
    localparam int CNT_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int CUR_W   = 32;
    localparam int BAD_W   = 32;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_START   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_REF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_REF  = 3'd5;

    localparam logic [CODE_W-1:0] UPPER_RST   = 16'hFFFF;
    localparam logic [CODE_W-1:0] LOWER_RST   = 16'h0000;
    localparam logic [CNT_W-1:0]  WIN_LEN_RST = 16'd6250;
    localparam logic [CODE_W-1:0] CODE_FLOOR  = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_FULL   = 16'hFFFF;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CODE_W-1:0] ctrl_code;
        logic [CODE_W-1:0] obs_code;
    } item_t;

    typedef struct packed {
        logic                    select_neg;
        logic                    window_done;
        logic                    locked;
        logic [CNT_W-1:0]        samples_in_window;
        logic signed [CUR_W-1:0] ctrl_current;
        logic signed [CUR_W-1:0] obs_current;
        logic [CNT_W-1:0]        pos_ticks;
        logic [CNT_W-1:0]        neg_ticks;
        logic [BAD_W-1:0]        bad_reads;
    } result_t;

    typedef struct packed {
        logic [CODE_W-1:0]       upper_code;
        logic [CODE_W-1:0]       lower_code;
        logic [CNT_W-1:0]        window_len;
        logic [GAIN_W-1:0]       volt_gain;
        logic signed [CUR_W-1:0] pos_ref_current;
        logic signed [CUR_W-1:0] neg_ref_current;
    } cfg_t;

    // one classified item on its way from front to back
    typedef struct packed {
        logic              select_neg;
        logic              window_done;
        logic              locked;
        logic [CNT_W-1:0]  samples_in_window;
        logic [CNT_W-1:0]  pos_ticks;
        logic [CNT_W-1:0]  neg_ticks;
        logic [BAD_W-1:0]  bad_reads;
        logic [CODE_W-1:0] first_ctrl;
        logic [CODE_W-1:0] last_ctrl;
        logic [CODE_W-1:0] first_obs;
        logic [CODE_W-1:0] last_obs;
        logic [CNT_W-1:0]  win_pos;
        logic [CNT_W-1:0]  win_neg;
    } entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_DIV,
        BK_SAT,
        BK_OUT
    } back_state_t;

endpackage

/* rtl/core/hcbm_front.sv */
// Front end: accepts items, runs the window and phase control, counts bad reads.
// Depends on hcbm_pkg; pushes one classified entry per item into the queue.
module hcbm_front (
    input  logic           clk,
    input  logic           rst_n,
    input  hcbm_pkg::cfg_t cfg,
    input  hcbm_pkg::item_t item,
    input  logic           accept,
    output hcbm_pkg::entry_t entry
);
    import hcbm_pkg::*;

    logic              phase_neg_reg, phase_neg_next;
    logic [CNT_W-1:0]  pos_count_reg, pos_count_next;
    logic [CNT_W-1:0]  neg_count_reg, neg_count_next;
    logic [CNT_W-1:0]  tick_index_reg, tick_index_next;
    logic              lock_reg, lock_next;
    logic [CODE_W-1:0] first_ctrl_reg, first_ctrl_next;
    logic [CODE_W-1:0] first_obs_reg, first_obs_next;
    logic [CNT_W-1:0]  held_pos_reg, held_pos_next;
    logic [CNT_W-1:0]  held_neg_reg, held_neg_next;
    logic [BAD_W-1:0]  bad_reg, bad_next;
    logic              done;
    logic [CNT_W-1:0]  pos_inc, neg_inc, tick_inc;

    always_comb
    begin
        phase_neg_next  = phase_neg_reg;
        pos_count_next  = pos_count_reg;
        neg_count_next  = neg_count_reg;
        tick_index_next = tick_index_reg;
        lock_next       = lock_reg;
        first_ctrl_next = first_ctrl_reg;
        first_obs_next  = first_obs_reg;
        held_pos_next   = held_pos_reg;
        held_neg_next   = held_neg_reg;
        bad_next        = bad_reg;
        done            = 1'b0;
        pos_inc         = pos_count_reg;
        neg_inc         = neg_count_reg;
        tick_inc        = tick_index_reg + 16'd1;
        case (item.operation)
            OP_TICK:
            begin
                if (item.obs_code == CODE_FLOOR || item.obs_code == CODE_FULL)
                begin
                    bad_next = bad_reg + 32'd1;
                end
                if (!lock_reg)
                begin
                    if (tick_index_reg == '0)
                    begin
                        first_ctrl_next = item.ctrl_code;
                        first_obs_next  = item.obs_code;
                    end
                    if (!phase_neg_reg)
                    begin
                        pos_inc = pos_count_reg + 16'd1;
                        if (item.ctrl_code >= cfg.upper_code)
                        begin
                            phase_neg_next = 1'b1;
                        end
                    end
                    else
                    begin
                        neg_inc = neg_count_reg + 16'd1;
                        if (item.ctrl_code <= cfg.lower_code)
                        begin
                            phase_neg_next = 1'b0;
                        end
                    end
                    pos_count_next  = pos_inc;
                    neg_count_next  = neg_inc;
                    tick_index_next = tick_inc;
                    if (tick_inc >= cfg.window_len)
                    begin
                        done            = 1'b1;
                        held_pos_next   = pos_inc;
                        held_neg_next   = neg_inc;
                        lock_next       = 1'b1;
                        tick_index_next = '0;
                        pos_count_next  = '0;
                        neg_count_next  = '0;
                    end
                end
            end
            OP_RELEASE:
            begin
                lock_next = 1'b0;
            end
            OP_START:
            begin
                pos_count_next  = '0;
                neg_count_next  = '0;
                tick_index_next = '0;
                lock_next       = 1'b0;
                held_pos_next   = '0;
                held_neg_next   = '0;
                phase_neg_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        entry.select_neg        = phase_neg_next;
        entry.window_done       = done;
        entry.locked            = lock_next;
        entry.samples_in_window = tick_index_next;
        entry.pos_ticks         = held_pos_next;
        entry.neg_ticks         = held_neg_next;
        entry.bad_reads         = bad_next;
        entry.first_ctrl        = first_ctrl_next;
        entry.last_ctrl         = item.ctrl_code;
        entry.first_obs         = first_obs_next;
        entry.last_obs          = item.obs_code;
        entry.win_pos           = pos_inc;
        entry.win_neg           = neg_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_neg_reg  <= 1'b0;
            pos_count_reg  <= '0;
            neg_count_reg  <= '0;
            tick_index_reg <= '0;
            lock_reg       <= 1'b0;
            held_pos_reg   <= '0;
            held_neg_reg   <= '0;
            bad_reg        <= '0;
        end
        else if (accept)
        begin
            phase_neg_reg  <= phase_neg_next;
            pos_count_reg  <= pos_count_next;
            neg_count_reg  <= neg_count_next;
            tick_index_reg <= tick_index_next;
            lock_reg       <= lock_next;
            held_pos_reg   <= held_pos_next;
            held_neg_reg   <= held_neg_next;
            bad_reg        <= bad_next;
        end
    end

    // first codes are always written before they are used
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_ctrl_reg <= first_ctrl_next;
            first_obs_reg  <= first_obs_next;
        end
    end

endmodule

/* rtl/core/hcbm_queue.sv */
// Small FIFO of classified entries between front and back.
// Depends on hcbm_pkg for the entry type.
module hcbm_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hcbm_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output hcbm_pkg::entry_t head_entry
);
    import hcbm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    entry_t            mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/core/hcbm_back.sv */
// Back end: turns queue entries into result items; computes window currents
// with a shared multiply stage and a restoring divider. Depends on hcbm_pkg.
module hcbm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  hcbm_pkg::cfg_t    cfg,
    input  logic              head_valid,
    input  hcbm_pkg::entry_t  head_entry,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output hcbm_pkg::result_t result
);
    import hcbm_pkg::*;

    localparam int PG_W  = GAIN_W + 1 + CODE_W + 1;    // gain * code difference
    localparam int PR_W  = CNT_W + 1 + CUR_W;          // count * reference
    localparam int NUM_W = PR_W + 1;
    localparam int DEN_W = CNT_W + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);
    localparam logic [NUM_W-1:0]  POS_LIM = NUM_W'(64'h7FFF_FFFF);
    localparam logic [NUM_W-1:0]  NEG_LIM = NUM_W'(64'h8000_0000);
    localparam logic signed [CUR_W-1:0] CUR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CUR_W-1:0] CUR_MIN = 32'sh8000_0000;

    back_state_t state_reg, state_next;

    entry_t                   entry_reg;
    logic                     chan_reg;
    logic signed [PG_W-1:0]   prod_g_reg;
    logic signed [PR_W-1:0]   prod_p_reg;
    logic signed [PR_W-1:0]   prod_n_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     den_zero_reg;
    logic                     num_neg_reg;
    logic [NUM_W-1:0]         dvd_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [CUR_W-1:0]  held_ctrl_reg;
    logic signed [CUR_W-1:0]  held_obs_reg;
    logic                     res_valid_reg;
    result_t                  res_reg;

    logic                     slot_free;
    logic                     load_pass;
    logic                     load_done;
    logic                     capture;

    logic [CODE_W-1:0]        first_code, last_code;
    logic signed [CODE_W:0]   diff;
    logic signed [CNT_W:0]    neg_m1;
    logic [DEN_W-1:0]         tick_sum;
    logic signed [NUM_W-1:0]  num;
    logic [DEN_W:0]           trial;
    logic signed [CUR_W-1:0]  sat_val;

    assign slot_free = !res_valid_reg || !result_stall;

    // control
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_pass  = 1'b0;
        load_done  = 1'b0;
        capture    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    if (!head_entry.window_done)
                    begin
                        if (slot_free)
                        begin
                            pop       = 1'b1;
                            load_pass = 1'b1;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        capture    = 1'b1;
                        state_next = BK_MUL;
                    end
                end
            end
            BK_MUL: state_next = BK_SUM;
            BK_SUM: state_next = BK_DIV;
            BK_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = BK_SAT;
                end
            end
            BK_SAT: state_next = chan_reg ? BK_OUT : BK_MUL;
            BK_OUT:
            begin
                if (slot_free)
                begin
                    load_done  = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_comb
    begin
        first_code = chan_reg ? entry_reg.first_obs : entry_reg.first_ctrl;
        last_code  = chan_reg ? entry_reg.last_obs  : entry_reg.last_ctrl;
        diff       = $signed({1'b0, last_code}) - $signed({1'b0, first_code});
        neg_m1     = $signed({1'b0, entry_reg.win_neg}) - 17'sd1;
        tick_sum   = {1'b0, entry_reg.win_pos} + {1'b0, entry_reg.win_neg};
        num        = NUM_W'(prod_g_reg) - NUM_W'(prod_p_reg) - NUM_W'(prod_n_reg);
        trial      = {rem_reg, dvd_reg[NUM_W-1]} - {1'b0, den_reg};
        if (den_zero_reg)
        begin
            sat_val = '0;
        end
        else if (num_neg_reg)
        begin
            sat_val = (dvd_reg > NEG_LIM) ? CUR_MIN : -$signed(dvd_reg[CUR_W-1:0]);
        end
        else
        begin
            sat_val = (dvd_reg > POS_LIM) ? CUR_MAX : $signed(dvd_reg[CUR_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            entry_reg <= head_entry;
        end
        case (state_reg)
            BK_MUL:
            begin
                prod_g_reg   <= $signed({1'b0, cfg.volt_gain}) * diff;
                prod_p_reg   <= $signed({1'b0, entry_reg.win_pos}) * cfg.pos_ref_current;
                prod_n_reg   <= neg_m1 * cfg.neg_ref_current;
                den_zero_reg <= (tick_sum <= 17'd1);
                den_reg      <= tick_sum - 17'd1;
            end
            BK_SUM:
            begin
                num_neg_reg <= num[NUM_W-1];
                dvd_reg     <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                rem_reg     <= '0;
                step_reg    <= '0;
            end
            BK_DIV:
            begin
                if (!trial[DEN_W])
                begin
                    rem_reg <= trial[DEN_W-1:0];
                end
                else
                begin
                    rem_reg <= {rem_reg[DEN_W-2:0], dvd_reg[NUM_W-1]};
                end
                dvd_reg  <= {dvd_reg[NUM_W-2:0], !trial[DEN_W]};
                step_reg <= step_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg      <= 1'b0;
            held_ctrl_reg <= '0;
            held_obs_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (capture)
            begin
                chan_reg <= 1'b0;
            end
            else if (state_reg == BK_SAT)
            begin
                chan_reg <= 1'b1;
                // no new result is loaded while the back is busy, so held values update here
                if (chan_reg)
                begin
                    held_obs_reg <= sat_val;
                end
                else
                begin
                    held_ctrl_reg <= sat_val;
                end
            end
            if (load_pass || load_done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pass || load_done)
        begin
            res_reg.select_neg        <= load_pass ? head_entry.select_neg
                                                   : entry_reg.select_neg;
            res_reg.window_done       <= load_done;
            res_reg.locked            <= load_pass ? head_entry.locked : entry_reg.locked;
            res_reg.samples_in_window <= load_pass ? head_entry.samples_in_window
                                                   : entry_reg.samples_in_window;
            res_reg.ctrl_current      <= held_ctrl_reg;
            res_reg.obs_current       <= held_obs_reg;
            res_reg.pos_ticks         <= load_pass ? head_entry.pos_ticks
                                                   : entry_reg.pos_ticks;
            res_reg.neg_ticks         <= load_pass ? head_entry.neg_ticks
                                                   : entry_reg.neg_ticks;
            res_reg.bad_reads         <= load_pass ? head_entry.bad_reads
                                                   : entry_reg.bad_reads;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

/* rtl/core/hysteretic_charge_balance_meter_top.sv */
// Top level of the hysteretic charge balance meter: configuration registers,
// front end, entry queue and back end. Depends on hcbm_pkg and the hcbm_* modules.
//
// Every item gives one result item. Release, start, locked and ordinary ticks
// pass at one per cycle while the queue is not full, the back end is idle and
// the receiver does not stall. A tick that closes a window runs the back end
// through each of the two channels in turn: multiply, sum, the one-bit-per-step
// restoring divider and saturate, then the output state. The front keeps taking
// items meanwhile until the QUEUE_DEPTH-entry queue fills. Configuration is
// written through cfg_write/cfg_index/cfg_data; writes to unused indexes are
// ignored.
module hysteretic_charge_balance_meter_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  hcbm_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output hcbm_pkg::result_t                   result,
    input  logic                                cfg_write,
    input  logic [hcbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hcbm_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import hcbm_pkg::*;

    cfg_t   cfg_reg;
    entry_t front_entry;
    entry_t head_entry;
    logic   queue_full;
    logic   head_valid;
    logic   pop;
    logic   accept;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_code      <= UPPER_RST;
            cfg_reg.lower_code      <= LOWER_RST;
            cfg_reg.window_len      <= WIN_LEN_RST;
            cfg_reg.volt_gain       <= '0;
            cfg_reg.pos_ref_current <= '0;
            cfg_reg.neg_ref_current <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_UPPER:   cfg_reg.upper_code      <= cfg_data[CODE_W-1:0];
                REG_LOWER:   cfg_reg.lower_code      <= cfg_data[CODE_W-1:0];
                REG_WIN_LEN: cfg_reg.window_len      <= cfg_data[CNT_W-1:0];
                REG_GAIN:    cfg_reg.volt_gain       <= cfg_data[GAIN_W-1:0];
                REG_POS_REF: cfg_reg.pos_ref_current <= $signed(cfg_data[CUR_W-1:0]);
                REG_NEG_REF: cfg_reg.neg_ref_current <= $signed(cfg_data[CUR_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    hcbm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (item),
        .accept (accept),
        .entry  (front_entry)
    );

    hcbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    hcbm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* tb/tb_hysteretic_charge_balance_meter_top.sv */
// Self-checking testbench for hysteretic_charge_balance_meter_top: directed windows,
// then random window sequences under random idling, checked against a built-in predictor.
// Depends on hcbm_pkg and the RTL of the block only.
module tb_hysteretic_charge_balance_meter_top;
    import hcbm_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int     RANDOM_ITEMS = 920;
    localparam int     STALL_LIMIT  = 4000;
    localparam int     DRAIN_CYCLES = 150;
    localparam longint FA_MAX = 64'sd2147483647;
    localparam longint FA_MIN = -64'sd2147483648;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_DAT_W-1:0] cfg_data     = '0;

    hysteretic_charge_balance_meter_top dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor copy of the registers
    logic [CODE_W-1:0]       thr_upper = UPPER_RST;
    logic [CODE_W-1:0]       thr_lower = LOWER_RST;
    logic [CNT_W-1:0]        win_ticks = WIN_LEN_RST;
    logic [GAIN_W-1:0]       gain_fa   = '0;
    logic signed [CUR_W-1:0] ipos_fa   = '0;
    logic signed [CUR_W-1:0] ineg_fa   = '0;

    // predictor copy of the meter state
    logic                    sel_neg     = 1'b0;
    logic [CNT_W-1:0]        pos_run     = '0;
    logic [CNT_W-1:0]        neg_run     = '0;
    logic [CNT_W-1:0]        ticks_taken = '0;
    logic                    win_locked  = 1'b0;
    logic [CODE_W-1:0]       first_ctrl_code;
    logic [CODE_W-1:0]       first_obs_code;
    logic [CNT_W-1:0]        kept_pos    = '0;
    logic [CNT_W-1:0]        kept_neg    = '0;
    logic signed [CUR_W-1:0] kept_ctrl_fa = '0;
    logic signed [CUR_W-1:0] kept_obs_fa  = '0;
    logic [BAD_W-1:0]        bad_total   = '0;

    result_t pending_readouts[$];
    result_t want;
    int      mismatches  = 0;
    int      items_sent  = 0;
    int      idle_cycles = 0;
    int      hold_left   = 0;
    bit      idle_on     = 1'b1;

    function automatic logic signed [CUR_W-1:0] window_fa(input logic [CODE_W-1:0] first,
                                                          input logic [CODE_W-1:0] last);
        longint den;
        longint num;
        longint q;
        den = longint'(pos_run) + longint'(neg_run) - 1;
        if (den <= 0)
            return '0;
        num = longint'(gain_fa) * (longint'(last) - longint'(first))
            - longint'(pos_run) * longint'(ipos_fa)
            - (longint'(neg_run) - 1) * longint'(ineg_fa);
        q = num / den;
        if (q > FA_MAX)
            q = FA_MAX;
        if (q < FA_MIN)
            q = FA_MIN;
        return q[CUR_W-1:0];
    endfunction

    function automatic result_t next_meter_readout(input item_t it);
        result_t r;
        logic    done;
        done = 1'b0;
        case (it.operation)
            OP_TICK:
            begin
                if (it.obs_code == CODE_FLOOR || it.obs_code == CODE_FULL)
                    bad_total = bad_total + 1'b1;
                if (!win_locked)
                begin
                    if (ticks_taken == '0)
                    begin
                        first_ctrl_code = it.ctrl_code;
                        first_obs_code  = it.obs_code;
                    end
                    ticks_taken = ticks_taken + 1'b1;
                    if (!sel_neg)
                    begin
                        pos_run = pos_run + 1'b1;
                        if (it.ctrl_code >= thr_upper)
                            sel_neg = 1'b1;
                    end
                    else
                    begin
                        neg_run = neg_run + 1'b1;
                        if (it.ctrl_code <= thr_lower)
                            sel_neg = 1'b0;
                    end
                    if (ticks_taken >= win_ticks)
                    begin
                        kept_ctrl_fa = window_fa(first_ctrl_code, it.ctrl_code);
                        kept_obs_fa  = window_fa(first_obs_code, it.obs_code);
                        kept_pos     = pos_run;
                        kept_neg     = neg_run;
                        win_locked   = 1'b1;
                        done         = 1'b1;
                        ticks_taken  = '0;
                        pos_run      = '0;
                        neg_run      = '0;
                    end
                end
            end
            OP_RELEASE:
                win_locked = 1'b0;
            OP_START:
            begin
                pos_run     = '0;
                neg_run     = '0;
                ticks_taken = '0;
                win_locked  = 1'b0;
                kept_pos    = '0;
                kept_neg    = '0;
                sel_neg     = 1'b1;
            end
            default: ;
        endcase
        r.select_neg        = sel_neg;
        r.window_done       = done;
        r.locked            = win_locked;
        r.samples_in_window = ticks_taken;
        r.ctrl_current      = kept_ctrl_fa;
        r.obs_current       = kept_obs_fa;
        r.pos_ticks         = kept_pos;
        r.neg_ticks         = kept_neg;
        r.bad_reads         = bad_total;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v, input bit is_signed);
        if (act_v !== exp_v)
        begin
            if (is_signed)
                $error("%s: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
            else
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // register writes, accepted items and accepted results, all in edge order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                case (cfg_index)
                    REG_UPPER:   thr_upper = cfg_data[CODE_W-1:0];
                    REG_LOWER:   thr_lower = cfg_data[CODE_W-1:0];
                    REG_WIN_LEN: win_ticks = cfg_data[CNT_W-1:0];
                    REG_GAIN:    gain_fa   = cfg_data[GAIN_W-1:0];
                    REG_POS_REF: ipos_fa   = cfg_data[CUR_W-1:0];
                    REG_NEG_REF: ineg_fa   = cfg_data[CUR_W-1:0];
                    default: ;
                endcase
            if (item_valid && !item_stall)
                pending_readouts.push_back(next_meter_readout(item));
            if (result_valid && !result_stall)
            begin
                if (pending_readouts.size() == 0)
                begin
                    $error("result item arrived with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_readouts.pop_front();
                    compare_field("select_neg", 32'(want.select_neg),
                                  32'(result.select_neg), 1'b0);
                    compare_field("window_done", 32'(want.window_done),
                                  32'(result.window_done), 1'b0);
                    compare_field("locked", 32'(want.locked), 32'(result.locked), 1'b0);
                    compare_field("samples_in_window", 32'(want.samples_in_window),
                                  32'(result.samples_in_window), 1'b0);
                    compare_field("ctrl_current", want.ctrl_current,
                                  result.ctrl_current, 1'b1);
                    compare_field("obs_current", want.obs_current, result.obs_current, 1'b1);
                    compare_field("pos_ticks", 32'(want.pos_ticks),
                                  32'(result.pos_ticks), 1'b0);
                    compare_field("neg_ticks", 32'(want.neg_ticks),
                                  32'(result.neg_ticks), 1'b0);
                    compare_field("bad_reads", want.bad_reads, result.bad_reads, 1'b0);
                end
            end
        end
    end

    // receiver back-pressure in bursts
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                result_stall <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= $urandom_range(1, 19);
        end
    end

    // watchdog: cycles in a row with no handshake of any kind
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (item_valid && !item_stall)
            || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] ctrl,
                             input logic [CODE_W-1:0] obs);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{operation: op, ctrl_code: ctrl, obs_code: obs};
        do @(posedge clk); while (item_stall);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_readouts.size() != 0)
            @(posedge clk);
    endtask

    // all six registers; unused upper data bits are filled with noise
    task automatic program_meter(input cfg_t c);
        cfg_write <= 1'b1;
        cfg_index <= REG_UPPER;
        cfg_data  <= {16'($urandom), c.upper_code};
        @(posedge clk);
        cfg_index <= REG_LOWER;
        cfg_data  <= {16'($urandom), c.lower_code};
        @(posedge clk);
        cfg_index <= REG_WIN_LEN;
        cfg_data  <= {16'($urandom), c.window_len};
        @(posedge clk);
        cfg_index <= REG_GAIN;
        cfg_data  <= {8'($urandom), c.volt_gain};
        @(posedge clk);
        cfg_index <= REG_POS_REF;
        cfg_data  <= c.pos_ref_current;
        @(posedge clk);
        cfg_index <= REG_NEG_REF;
        cfg_data  <= c.neg_ref_current;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // no start since reset, so the window opens in the positive phase with n = 0
    task automatic test_positive_phase_window();
        program_meter('{upper_code: 16'hFFFF, lower_code: 16'h0000, window_len: 16'd3,
                        volt_gain: 24'd1000, pos_ref_current: 32'sd5,
                        neg_ref_current: -32'sd7});
        send_item(OP_TICK, 16'd100, CODE_FLOOR);
        send_item(OP_TICK, 16'd200, CODE_FULL);
        send_item(OP_TICK, 16'd400, 16'd500);
        send_item(OP_TICK, 16'hFFFF, CODE_FULL);
        send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        send_item(OP_RELEASE, 16'h0000, 16'h0000);
    endtask

    task automatic test_hysteresis();
        wait_drained();
        program_meter('{upper_code: 16'd40000, lower_code: 16'd20000, window_len: 16'd5,
                        volt_gain: 24'd3, pos_ref_current: 32'sd1000,
                        neg_ref_current: -32'sd1500});
        send_item(OP_START, 16'h5A5A, 16'hA5A5);
        send_item(OP_TICK, 16'd30000, 16'd1234);
        send_item(OP_TICK, 16'd20000, 16'd777);
        send_item(OP_TICK, 16'd40000, 16'd31);
        send_item(OP_TICK, 16'd20001, 16'd65534);
        send_item(OP_TICK, 16'd0, 16'd1);
        send_item(OP_RELEASE, 16'h1234, 16'h4321);
    endtask

    // window_len of one and of zero: the divisor is zero, currents read zero
    task automatic test_degenerate_windows();
        wait_drained();
        program_meter('{upper_code: 16'd100, lower_code: 16'd50, window_len: 16'd1,
                        volt_gain: 24'd77, pos_ref_current: 32'sd9,
                        neg_ref_current: 32'sd11});
        send_item(OP_TICK, 16'd3000, 16'd60000);
        send_item(OP_RELEASE, 16'd0, 16'd0);
        wait_drained();
        program_meter('{upper_code: 16'd100, lower_code: 16'd50, window_len: 16'd0,
                        volt_gain: 24'd77, pos_ref_current: 32'sd9,
                        neg_ref_current: 32'sd11});
        send_item(OP_TICK, 16'd20, 16'd5);
        send_item(OP_RELEASE, 16'd0, 16'd0);
    endtask

    // largest gain and code swing, extreme references: clips at both rails
    task automatic test_saturation();
        wait_drained();
        program_meter('{upper_code: 16'hFFFF, lower_code: 16'h0000, window_len: 16'd2,
                        volt_gain: 24'hFFFFFF, pos_ref_current: 32'sh8000_0000,
                        neg_ref_current: 32'sh7FFF_FFFF});
        send_item(OP_START, 16'd0, 16'd0);
        send_item(OP_TICK, 16'h0000, 16'hFFFF);
        send_item(OP_TICK, 16'hFFFF, 16'h0000);
        send_item(OP_RELEASE, 16'd0, 16'd0);
    endtask

    // window length dropped below the ticks already taken closes on the next tick
    task automatic test_shrink_window();
        wait_drained();
        program_meter('{upper_code: 16'd500, lower_code: 16'd400, window_len: 16'hFFFF,
                        volt_gain: 24'd12345, pos_ref_current: -32'sd333,
                        neg_ref_current: 32'sd4444});
        send_item(OP_START, 16'd0, 16'd0);
        send_item(OP_TICK, 16'd450, 16'd9000);
        send_item(OP_TICK, 16'd300, 16'd8000);
        send_item(OP_TICK, 16'd600, 16'd100);
        wait_drained();
        program_meter('{upper_code: 16'd500, lower_code: 16'd400, window_len: 16'd2,
                        volt_gain: 24'd12345, pos_ref_current: -32'sd333,
                        neg_ref_current: 32'sd4444});
        send_item(OP_TICK, 16'd50, 16'd7001);
        send_item(OP_RELEASE, 16'd0, 16'd0);
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        case ($urandom_range(0, 5))
            0:       c.upper_code = 16'hFFFF;
            1:       c.upper_code = 16'h0000;
            default: c.upper_code = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       c.lower_code = 16'h0000;
            1:       c.lower_code = 16'hFFFF;
            default: c.lower_code = 16'($urandom);
        endcase
        case ($urandom_range(0, 19))
            0:          c.window_len = 16'($urandom_range(0, 1));
            1:          c.window_len = 16'hFFFF;
            2, 3, 4:    c.window_len = 16'($urandom_range(11, 40));
            default:    c.window_len = 16'($urandom_range(2, 10));
        endcase
        case ($urandom_range(0, 5))
            0:       c.volt_gain = '0;
            1:       c.volt_gain = 24'hFFFFFF;
            2, 3:    c.volt_gain = 24'($urandom_range(0, 1000));
            default: c.volt_gain = 24'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       c.pos_ref_current = 32'sh8000_0000;
            1:       c.pos_ref_current = 32'sh7FFF_FFFF;
            2, 3:    c.pos_ref_current = 32'($urandom_range(0, 2000)) - 32'd1000;
            default: c.pos_ref_current = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       c.neg_ref_current = 32'sh8000_0000;
            1:       c.neg_ref_current = 32'sh7FFF_FFFF;
            2, 3:    c.neg_ref_current = 32'($urandom_range(0, 2000)) - 32'd1000;
            default: c.neg_ref_current = $urandom;
        endcase
        return c;
    endfunction

    // control codes bunch at the rails and around both switch points
    function automatic logic [CODE_W-1:0] pick_ctrl(input cfg_t c);
        int v;
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 65535;
            2:       v = int'(c.upper_code) + int'($urandom_range(0, 4)) - 2;
            3:       v = int'(c.lower_code) + int'($urandom_range(0, 4)) - 2;
            default: v = int'($urandom_range(0, 65535));
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[CODE_W-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] pick_obs();
        case ($urandom_range(0, 7))
            0:       return CODE_FLOOR;
            1:       return CODE_FULL;
            default: return 16'($urandom);
        endcase
    endfunction

    // usually a start, one full window, a few locked ticks, then a release
    task automatic run_window(input cfg_t c);
        int ticks;
        if ($urandom_range(0, 3) != 0)
            send_item(OP_START, 16'($urandom), 16'($urandom));
        if (c.window_len <= 1)
            ticks = 1;
        else if (c.window_len > 40)
            ticks = $urandom_range(1, 20);
        else
            ticks = c.window_len;
        repeat (ticks)
            send_item(OP_TICK, pick_ctrl(c), pick_obs());
        repeat ($urandom_range(0, 2))
            send_item(OP_TICK, pick_ctrl(c), pick_obs());
        send_item(OP_RELEASE, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_noise(input cfg_t c);
        repeat ($urandom_range(1, 6))
            send_item(2'($urandom_range(0, 3)), pick_ctrl(c), pick_obs());
    endtask

    task automatic test_random_windows();
        int   goal;
        bit   quiet;
        cfg_t c;
        goal  = items_sent + RANDOM_ITEMS;
        quiet = 1'b0;
        while (items_sent < goal)
        begin
            wait_drained();
            idle_on = !quiet && ($urandom_range(0, 2) != 0);
            c = random_settings();
            program_meter(c);
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 6) == 0)
                    send_noise(c);
                else
                    run_window(c);
            end
            quiet = (items_sent > goal - 120);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_positive_phase_window();
        test_hysteresis();
        test_degenerate_windows();
        test_saturation();
        test_shrink_window();
        test_random_windows();
        idle_on = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_readouts.size() != 0)
        begin
            $error("%0d expected result items never arrived", pending_readouts.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/hcbm_pkg.sv
rtl/core/hcbm_front.sv
rtl/core/hcbm_queue.sv
rtl/core/hcbm_back.sv
rtl/core/hysteretic_charge_balance_meter_top.sv
tb/tb_hysteretic_charge_balance_meter_top.sv
